// ===== rtl/pb_pkg.sv =====
package pb_pkg;

  localparam int unsigned NumCh = 5;
  localparam int unsigned ChIdxW = $clog2(NumCh);
  localparam int unsigned QDepth = 2;
  localparam int unsigned QIdxW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  // Register indexes on the configuration port
  localparam logic [1:0] CfgBlendMode = 2'd0;
  localparam logic [1:0] CfgChanCount = 2'd1;
  localparam logic [1:0] CfgMixFactor = 2'd2;

  // Blend mode codes
  localparam logic [1:0] ModeMix = 2'd0;
  localparam logic [1:0] ModeAdd = 2'd1;
  localparam logic [1:0] ModeMul = 2'd2;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_MIX,
    OP_ADD,
    OP_MUL
  } op_e;

  typedef struct packed {
    logic [7:0] lower_c0;
    logic [7:0] lower_c1;
    logic [7:0] lower_c2;
    logic [7:0] lower_c3;
    logic [7:0] lower_c4;
    logic [7:0] upper_c0;
    logic [7:0] upper_c1;
    logic [7:0] upper_c2;
    logic [7:0] upper_c3;
    logic [7:0] upper_c4;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_c0;
    logic [7:0] out_c1;
    logic [7:0] out_c2;
    logic [7:0] out_c3;
    logic [7:0] out_c4;
  } pixel_out_t;

  typedef logic [NumCh-1:0][7:0] ch_arr_t;

  // Classified item as it sits in the queue
  typedef struct packed {
    op_e              op;
    logic [7:0]       alpha;
    logic [NumCh-1:0] color_mask;
    logic [NumCh-1:0] alpha_mask;
    ch_arr_t          lower;
    ch_arr_t          upper;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic             full;
    logic [QCntW-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } back_status_t;

  function automatic ch_arr_t lower_arr(pixel_in_t p);
    return {p.lower_c4, p.lower_c3, p.lower_c2, p.lower_c1, p.lower_c0};
  endfunction

  function automatic ch_arr_t upper_arr(pixel_in_t p);
    return {p.upper_c4, p.upper_c3, p.upper_c2, p.upper_c1, p.upper_c0};
  endfunction

  function automatic pixel_out_t pack_out(ch_arr_t a);
    pixel_out_t p;
    p.out_c0 = a[0];
    p.out_c1 = a[1];
    p.out_c2 = a[2];
    p.out_c3 = a[3];
    p.out_c4 = a[4];
    return p;
  endfunction

  // Truncating x / 255, exact for x up to 255 * 255
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

// ===== rtl/pb_front.sv =====
module pb_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pb_pkg::pixel_in_t in_item_i,
  input  logic [1:0]        blend_mode_i,
  input  logic [2:0]        chan_count_i,
  input  logic [8:0]        mix_factor_i,
  input  pb_pkg::q_status_t q_status_i,
  output logic              push_o,
  output pb_pkg::entry_t    entry_o
);
  import pb_pkg::*;

  ch_arr_t          lo, hi;
  logic [2:0]       n;
  logic [2:0]       aidx;
  logic [16:0]      scaled;
  logic [8:0]       au_full;
  logic             pass;

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    lo      = lower_arr(in_item_i);
    hi      = upper_arr(in_item_i);
    n       = (chan_count_i > 3'(NumCh)) ? 3'(NumCh) : chan_count_i;
    aidx    = (n == 3'd0) ? 3'd0 : n - 3'd1;
    scaled  = 17'(hi[aidx]) * 17'(mix_factor_i);
    au_full = scaled[16:8];
    pass    = (n == 3'd0) || (blend_mode_i != ModeMix && blend_mode_i != ModeAdd &&
                              blend_mode_i != ModeMul);

    entry_o.lower = lo;
    entry_o.upper = hi;
    entry_o.alpha = au_full[8] ? 8'hFF : au_full[7:0];
    unique case (blend_mode_i)
      ModeMix: entry_o.op = OP_MIX;
      ModeAdd: entry_o.op = OP_ADD;
      ModeMul: entry_o.op = OP_MUL;
      default: entry_o.op = OP_PASS;
    endcase
    for (int i = 0; i < NumCh; i++) begin
      entry_o.color_mask[i] = !pass && (3'(i) < aidx);
      entry_o.alpha_mask[i] = !pass && (3'(i) == aidx);
    end
    if (pass) begin
      entry_o.op = OP_PASS;
    end
  end

endmodule

// ===== rtl/pb_queue.sv =====
module pb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pb_pkg::entry_t    push_data_i,
  input  logic              pop_i,
  output pb_pkg::entry_t    head_o,
  output pb_pkg::q_status_t status_o
);
  import pb_pkg::*;

  entry_t           mem_q [QDepth];
  logic [QIdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + QCntW'(1);
    end else if (do_pop && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QIdxW'(QDepth - 1)) ? '0 : wr_ptr_q + QIdxW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QIdxW'(QDepth - 1)) ? '0 : rd_ptr_q + QIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.valid = (count_q != '0);
  assign status_o.full  = (count_q == QCntW'(QDepth));
  assign status_o.count = count_q;

endmodule

// ===== rtl/pb_back.sv =====
module pb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pb_pkg::entry_t       head_i,
  input  pb_pkg::q_status_t    q_status_i,
  output pb_pkg::back_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pb_pkg::pixel_out_t   out_item_o
);
  import pb_pkg::*;

  typedef logic [NumCh-1:0][15:0] prod_arr_t;

  logic       adv;
  logic       s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  entry_t     s1_q, s2_q, s3_q;
  prod_arr_t  s1_du_q;
  ch_arr_t    s2_b_q, s2_b_d;
  prod_arr_t  s3_p0_q, s3_p1_q, s3_p0_d, s3_p1_d;
  ch_arr_t    res_d;
  pixel_out_t out_q;

  // Whole chain moves together whenever the output slot frees
  assign adv = !out_vld_q || !out_stall_i;

  assign status_o.pop   = adv && q_status_i.valid;
  assign status_o.empty = !s1_vld_q && !s2_vld_q && !s3_vld_q;

  // Stage 2: pick target value, multiply mode pulls it to down*up/255
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      s2_b_d[i] = (s1_q.op == OP_MUL) ? div255(s1_du_q[i]) : s1_q.upper[i];
    end
  end

  // Stage 3: weight products
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      s3_p0_d[i] = 16'(s2_q.lower[i]) * 16'(8'hFF - s2_q.alpha);
      if (s2_q.alpha_mask[i]) begin
        s3_p1_d[i] = 16'(8'hFF - s2_q.lower[i]) * 16'(s2_q.alpha);
      end else begin
        s3_p1_d[i] = 16'(s2_b_q[i]) * 16'(s2_q.alpha);
      end
    end
  end

  // Final combine per lane
  always_comb begin
    logic [16:0] sum;
    logic [8:0]  acc;
    for (int i = 0; i < NumCh; i++) begin
      sum = 17'(s3_p0_q[i]) + 17'(s3_p1_q[i]);
      acc = 9'(s3_q.lower[i]) + 9'(div255(s3_p1_q[i]));
      if (s3_q.color_mask[i]) begin
        case (s3_q.op)
          OP_ADD:  res_d[i] = acc[8] ? 8'hFF : acc[7:0];
          default: res_d[i] = div255(sum[15:0]);
        endcase
      end else if (s3_q.alpha_mask[i]) begin
        res_d[i] = acc[7:0];
      end else begin
        res_d[i] = s3_q.lower[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= q_status_i.valid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= head_i;
      for (int i = 0; i < NumCh; i++) begin
        s1_du_q[i] <= 16'(head_i.lower[i]) * 16'(head_i.upper[i]);
      end
      s2_q    <= s1_q;
      s2_b_q  <= s2_b_d;
      s3_q    <= s2_q;
      s3_p0_q <= s3_p0_d;
      s3_p1_q <= s3_p1_d;
      out_q   <= pack_out(res_d);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/pixel_blend_8bit.sv =====
// Pixel blender: composites one upper pixel onto one lower pixel of up to five
// 8-bit channels, the last channel in use being alpha, in mix, saturating-add
// or multiply mode with a Q1.8 layer opacity (other settings pass the lower
// pixel through). One pixel is taken and one delivered per clock when the
// output is not stalled. An accepted item is written into the two-entry queue,
// then carried through three arithmetic stages and the output register of the
// back end. The back end advances as one block whenever its output register is
// empty or being taken, so a stalled output holds every stage. The input stalls
// only when the queue is full, i.e. once two more items have been taken while
// the output was held; the input reopens in the cycle after the output is
// released. Write the configuration registers (index 0 blend mode, 1 channel
// count, 2 mix factor) only while no item is in flight; the configuration port
// is always ready.
module pixel_blend_8bit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pb_pkg::pixel_in_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pb_pkg::pixel_out_t out_item_o
);
  import pb_pkg::*;

  logic [1:0]   blend_mode_q;
  logic [2:0]   chan_count_q;
  logic [8:0]   mix_factor_q;

  logic         push;
  entry_t       push_entry;
  entry_t       head;
  q_status_t    q_status;
  back_status_t back_status;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; writes to unused indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q <= ModeMix;
      chan_count_q <= 3'd4;
      mix_factor_q <= 9'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgBlendMode: blend_mode_q <= cfg_data_i[1:0];
        CfgChanCount: chan_count_q <= cfg_data_i[2:0];
        CfgMixFactor: mix_factor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: accept, scale alpha, classify lanes
  pb_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .blend_mode_i (blend_mode_q),
    .chan_count_i (chan_count_q),
    .mix_factor_i (mix_factor_q),
    .q_status_i   (q_status),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Decouple front and back
  pb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (back_status.pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // Back end: per-lane arithmetic and output register
  pb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .status_o    (back_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // An accepted item is in the queue on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> q_status.count != '0)
    else $error("accepted item missing from queue");

  // Nothing in flight means no output can appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && back_status.empty && !q_status.valid |=> !out_valid_o)
    else $error("output item without a source");

  // A stalled output holds the back end, so the queue is not popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !back_status.pop)
    else $error("queue popped while output stalled");

endmodule
